### hw/rtl/wrc_pkg.sv
// shared types and constants for the weighted result cache
package wrc_pkg;

  localparam int SLOTS  = 32;
  localparam int IDX_W  = 5;
  localparam int CNT_W  = 6;
  localparam int KEY_W  = 32;
  localparam int TOT_W  = 24;
  localparam int COST_W = 16;
  localparam int HND_W  = 16;
  localparam int WGT_W  = 40;
  localparam int THR_W  = 47;
  localparam int FUNC_W = 2;

  localparam logic [CNT_W-1:0] CAP_DEFAULT = 6'd20;
  localparam logic [CNT_W-1:0] CAP_MAX     = 6'd32;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_INSERT = 2'd1,
    FUNC_FETCH  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic init;
    logic scan;
    logic finish;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    func_t func;
    logic  full;
    logic  scan_end;
    logic  out_free;
  } sts_t;

endpackage

### hw/rtl/weighted_result_cache.sv
// weighted result cache: one item at a time; lookup and full-cache insert scan filled slots
// a lookup or an insert into a full cache goes through the slot scan before its result is
//   valid; other operations skip the scan
// a new item is taken only once the last result can move into the result register; the scan
//   uses the single read port, which it walks one slot per cycle
// reset: fill count cleared, capacity back to 20; slot memories are not cleared
module weighted_result_cache
  import wrc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wen,
  input  logic [CNT_W-1:0]   cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [FUNC_W-1:0]  func,
  input  logic [KEY_W-1:0]   key,
  input  logic [TOT_W-1:0]   total_entries,
  input  logic [COST_W-1:0]  cost,
  input  logic [HND_W-1:0]   handle,
  input  logic [IDX_W-1:0]   slot_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               status,
  output logic [IDX_W-1:0]   slot,
  output logic [HND_W-1:0]   result_handle
);

  cmd_t cmd;
  sts_t sts;

  // sequencing
  wrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // storage and arithmetic
  wrc_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .func          (func),
    .key           (key),
    .total_entries (total_entries),
    .cost          (cost),
    .handle        (handle),
    .slot_index    (slot_index),
    .cmd           (cmd),
    .sts           (sts),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .status        (status),
    .slot          (slot),
    .result_handle (result_handle)
  );

endmodule

### hw/rtl/wrc_ctrl.sv
// controller state machine for the weighted result cache
module wrc_ctrl
  import wrc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_INIT = 5'b00100,
    ST_SCAN = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_MUL;
      end
      ST_MUL: begin
        state_next = ST_INIT;
      end
      ST_INIT: begin
        if (sts.func == FUNC_LOOKUP || (sts.func == FUNC_INSERT && sts.full)) begin
          state_next = ST_SCAN;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_SCAN: begin
        if (sts.scan_end) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // command decode
  always_comb begin
    cmd.load   = (state == ST_IDLE) && in_valid;
    cmd.mul    = (state == ST_MUL);
    cmd.init   = (state == ST_INIT);
    cmd.scan   = (state == ST_SCAN);
    cmd.finish = (state == ST_DONE) && sts.out_free;
  end

  assign in_stall = (state != ST_IDLE);

endmodule

### hw/rtl/wrc_dp.sv
// datapath of the weighted result cache: slot memories, weight math, scan and result register
module wrc_dp
  import wrc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wen,
  input  logic [CNT_W-1:0]   cfg_wdata,
  input  logic [FUNC_W-1:0]  func,
  input  logic [KEY_W-1:0]   key,
  input  logic [TOT_W-1:0]   total_entries,
  input  logic [COST_W-1:0]  cost,
  input  logic [HND_W-1:0]   handle,
  input  logic [IDX_W-1:0]   slot_index,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic               out_stall,
  output logic               out_valid,
  output logic               status,
  output logic [IDX_W-1:0]   slot,
  output logic [HND_W-1:0]   result_handle
);

  logic [CNT_W-1:0]  capacity;
  logic [CNT_W-1:0]  cap_eff;
  logic [CNT_W-1:0]  fill;
  logic [CNT_W-1:0]  idx;

  func_t             func_q;
  logic [KEY_W-1:0]  key_q;
  logic [TOT_W-1:0]  tot_q;
  logic [COST_W-1:0] cost_q;
  logic [HND_W-1:0]  hnd_in_q;
  logic [IDX_W-1:0]  want_q;

  logic [WGT_W-1:0]  weight_q;
  logic [THR_W-1:0]  thr;
  logic [THR_W-1:0]  best;
  logic              found;
  logic              full_q;
  logic [IDX_W-1:0]  pos;
  logic [HND_W-1:0]  hnd_q;

  logic [KEY_W-1:0]  mem_key [SLOTS];
  logic [WGT_W-1:0]  mem_wgt [SLOTS];
  logic [HND_W-1:0]  mem_hnd [SLOTS];

  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              rd_vld;
  logic [IDX_W-1:0]  rd_idx;
  logic [KEY_W-1:0]  rd_key;
  logic [WGT_W-1:0]  rd_wgt;
  logic [HND_W-1:0]  rd_hnd;

  logic              full;
  logic              scan_end;
  logic              want_hit;
  logic              wr_en;
  logic              out_free;

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_DEFAULT;
    end else if (cfg_wen) begin
      capacity <= cfg_wdata;
    end
  end

  // zero means default, above the slot count saturates
  always_comb begin
    if (capacity == '0) begin
      cap_eff = CAP_DEFAULT;
    end else if (capacity > CAP_MAX) begin
      cap_eff = CAP_MAX;
    end else begin
      cap_eff = capacity;
    end
  end

  assign full     = (fill >= cap_eff);
  assign scan_end = (idx >= fill);
  assign want_hit = ({1'b0, want_q} < fill);
  assign out_free = !out_valid || !out_stall;

  assign sts.func     = func_q;
  assign sts.full     = full;
  assign sts.scan_end = scan_end;
  assign sts.out_free = out_free;

  // input item capture on transfer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q   <= func_t'(func);
      key_q    <= key;
      tot_q    <= total_entries;
      cost_q   <= cost;
      hnd_in_q <= handle;
      want_q   <= slot_index;
    end
  end

  // weight product, then threshold as 64w + 32w + 4w
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      weight_q <= WGT_W'(tot_q) * WGT_W'(cost_q);
    end
  end

  assign thr = (THR_W'(weight_q) << 6) + (THR_W'(weight_q) << 5) + (THR_W'(weight_q) << 2);

  // scan address counter
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      idx <= '0;
    end else if (cmd.scan && !scan_end) begin
      idx <= idx + 1'b1;
    end
  end

  // memory read port: fetch slot at init, scan slots afterwards
  assign rd_en   = cmd.init ? want_hit : (cmd.scan && !scan_end);
  assign rd_addr = cmd.init ? want_q : idx[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key <= mem_key[rd_addr];
      rd_wgt <= mem_wgt[rd_addr];
      rd_hnd <= mem_hnd[rd_addr];
    end
    rd_idx <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.scan && !scan_end;
    end
  end

  // memory write port
  assign wr_en = cmd.finish && (func_q == FUNC_INSERT) && found;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_key[pos] <= key_q;
      mem_wgt[pos] <= weight_q;
      mem_hnd[pos] <= hnd_in_q;
    end
  end

  // search state: first key match or lowest weight under threshold
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      best   <= thr;
      full_q <= full;
      found  <= ((func_q == FUNC_INSERT) && !full) || ((func_q == FUNC_FETCH) && want_hit);
      pos    <= (func_q == FUNC_INSERT) ? fill[IDX_W-1:0] : want_q;
    end else if (rd_vld) begin
      if (func_q == FUNC_LOOKUP) begin
        if (!found && (rd_key == key_q)) begin
          found <= 1'b1;
          pos   <= rd_idx;
          hnd_q <= rd_hnd;
        end
      end else if (func_q == FUNC_INSERT) begin
        if (THR_W'(rd_wgt) < best) begin
          found <= 1'b1;
          pos   <= rd_idx;
          best  <= THR_W'(rd_wgt);
        end
      end
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.finish && (func_q == FUNC_INSERT) && !full_q) begin
      fill <= fill + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status <= !found;
      slot   <= found ? pos : '0;
      if (found && (func_q == FUNC_LOOKUP)) begin
        result_handle <= hnd_q;
      end else if (found && (func_q == FUNC_FETCH)) begin
        result_handle <= rd_hnd;
      end else begin
        result_handle <= '0;
      end
    end
  end

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst) fill <= CAP_MAX)
    else $error("fill count beyond slot count");

  a_read_filled: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> ({1'b0, rd_idx} < fill))
    else $error("scan read of an unfilled slot");

  a_hit_in_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !status) |-> ({1'b0, slot} < fill))
    else $error("reported slot not below fill count");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (slot == '0 && result_handle == '0))
    else $error("miss result carries nonzero fields");

  a_insert_write: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> (out_valid && !status))
    else $error("slot write without a stored result");

endmodule
